// ===== rtl/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
package tcw_pkg;

    localparam int FUNC_W = 3;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE    = 8'd10;
    localparam logic [ATTR_W-1:0] CURSOR_ATTR_RST = 8'd15;

    // register index, taken from paddr[2]
    localparam logic REG_IDX_CURSOR_ATTR = 1'b0;

    typedef enum logic [FUNC_W-1:0] {
        FN_PRINT     = 3'd0,
        FN_PUT       = 3'd1,
        FN_PLACE     = 3'd2,
        FN_CLR_KEEP  = 3'd3,
        FN_CLR_HOME  = 3'd4,
        FN_READ      = 3'd5
    } t_func;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PLACE,
        ST_SCROLL,
        ST_READ,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              ok;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
    } t_result;

endpackage

// ===== rtl/tcw_req_if.sv =====
// Request channel: console command in.
interface tcw_req_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CHAR_W-1:0] character;
    logic [ATTR_W-1:0] attr;

    modport source (output valid, func, row, col, character, attr, input ready);
    modport sink   (input valid, func, row, col, character, attr, output ready);
endinterface

// ===== rtl/tcw_rsp_if.sv =====
// Response channel: status, cursor and read cell out.
interface tcw_rsp_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic              ok;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;

    modport source (output valid, ok, cursor_row, cursor_col, cell_char, cell_attr,
                    input ready);
    modport sink   (input valid, ok, cursor_row, cursor_col, cell_char, cell_attr,
                    output ready);
endinterface

// ===== rtl/tcw_cfg.sv =====
// APB register block holding the cursor attribute.
module tcw_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_psel,
    input  logic                             i_penable,
    input  logic                             i_pwrite,
    input  logic [tcw_pkg::CFG_ADDR_W-1:0]   i_paddr,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]   i_pwdata,
    output logic [tcw_pkg::CFG_DATA_W-1:0]   o_prdata,
    output logic                             o_pready,
    output logic [tcw_pkg::ATTR_W-1:0]       o_cursor_attr
);
    import tcw_pkg::*;

    logic [ATTR_W-1:0] r_cursor_attr;
    logic              wr_en;

    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite && o_pready
                      && (i_paddr[2] == REG_IDX_CURSOR_ATTR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_attr <= CURSOR_ATTR_RST;
        end else if (wr_en) begin
            r_cursor_attr <= i_pwdata[ATTR_W-1:0];
        end
    end

    always_comb begin
        o_prdata = '0;
        if (i_paddr[2] == REG_IDX_CURSOR_ATTR) begin
            o_prdata = {{(CFG_DATA_W-ATTR_W){1'b0}}, r_cursor_attr};
        end
    end

    assign o_cursor_attr = r_cursor_attr;

endmodule

// ===== rtl/tcw_cell_ram.sv =====
// Character/attribute cell memory: one write port, one registered read port.
module tcw_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [tcw_pkg::CELL_W-1:0]  i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [tcw_pkg::CELL_W-1:0]  o_rdata
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tcw_addr_unit.sv =====
// Shared cell address unit: row*COLUMNS + col and bounds check.
module tcw_addr_unit #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80,
    parameter int AW      = 11
) (
    input  logic [tcw_pkg::ROW_W-1:0] i_row,
    input  logic [tcw_pkg::COL_W-1:0] i_col,
    output logic [AW-1:0]             o_addr,
    output logic                      o_in_bounds
);
    import tcw_pkg::*;

    assign o_in_bounds = ({1'b0, i_row} < (ROW_W+1)'(ROWS))
                         && ({1'b0, i_col} < (COL_W+1)'(COLUMNS));
    assign o_addr = AW'(i_row * COLUMNS) + AW'(i_col);

endmodule

// ===== rtl/tcw_ctrl.sv =====
// Command sequencer: cell writes and reads, cursor placement, clear and scroll sweeps.
module tcw_ctrl #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80,
    parameter int AW      = 11
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tcw_req_if.sink                     i_req,
    input  logic [tcw_pkg::ATTR_W-1:0]  i_cursor_attr,
    // address unit
    output logic [tcw_pkg::ROW_W-1:0]   o_au_row,
    output logic [tcw_pkg::COL_W-1:0]   o_au_col,
    input  logic [AW-1:0]               i_au_addr,
    input  logic                        i_au_in_bounds,
    // cell memory
    output logic                        o_we,
    output logic [AW-1:0]               o_waddr,
    output logic [tcw_pkg::CELL_W-1:0]  o_wdata,
    output logic [AW-1:0]               o_raddr,
    input  logic [tcw_pkg::CELL_W-1:0]  i_rdata,
    // result
    output logic                        o_res_valid,
    output tcw_pkg::t_result            o_res,
    input  logic                        i_res_ready
);
    import tcw_pkg::*;

    localparam int NCELLS = ROWS * COLUMNS;
    localparam int CW     = $clog2(NCELLS + 1);
    localparam logic [CW-1:0] LAST_IDX  = CW'(NCELLS - 1);
    localparam logic [CW-1:0] END_IDX   = CW'(NCELLS);
    localparam logic [CW-1:0] MOVE_CNT  = CW'(NCELLS - COLUMNS);
    localparam logic [CW-1:0] ROW_STEP  = CW'(COLUMNS);

    t_state            r_state, n_state;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [AW-1:0]     r_cur_addr, n_cur_addr;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_mark, n_mark;
    logic              r_ok, n_ok;
    logic [CHAR_W-1:0] r_cc, n_cc;
    logic [ATTR_W-1:0] r_ca, n_ca;

    logic              fire;
    logic [COL_W:0]    p_col;
    logic              adv_line;
    logic [ROW_W:0]    p_row;
    logic [COL_W:0]    p_colf;
    logic              p_scroll;
    logic [CW-1:0]     w_idx;
    logic [CELL_W-1:0] cursor_cell;

    assign i_req.ready = (r_state == ST_IDLE);
    assign fire        = i_req.valid && i_req.ready;

    // next cursor position for a print
    assign p_col    = {1'b0, r_col} + (COL_W+1)'(1);
    assign adv_line = (i_req.character == NEWLINE_CODE) || (p_col >= (COL_W+1)'(COLUMNS));
    assign p_row    = adv_line ? ({1'b0, r_row} + (ROW_W+1)'(1)) : {1'b0, r_row};
    assign p_colf   = adv_line ? '0 : p_col;
    assign p_scroll = (p_row >= (ROW_W+1)'(ROWS));

    assign w_idx       = r_cnt - CW'(1);
    assign cursor_cell = {i_cursor_attr, {CHAR_W{1'b0}}};

    always_comb begin
        if (t_func'(i_req.func) == FN_PRINT) begin
            o_au_row = p_row[ROW_W-1:0];
            o_au_col = p_colf[COL_W-1:0];
        end else begin
            o_au_row = i_req.row;
            o_au_col = i_req.col;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_col      = r_col;
        n_cur_addr = r_cur_addr;
        n_cnt      = r_cnt;
        n_mark     = r_mark;
        n_ok       = r_ok;
        n_cc       = r_cc;
        n_ca       = r_ca;
        o_we       = 1'b0;
        o_waddr    = '0;
        o_wdata    = '0;
        o_raddr    = '0;

        case (r_state)
            ST_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_cnt[AW-1:0];
                if (r_mark && (r_cnt[AW-1:0] == r_cur_addr)) begin
                    o_wdata = cursor_cell;
                end
                if (r_cnt == LAST_IDX) begin
                    n_cnt   = '0;
                    n_state = r_mark ? ST_DONE : ST_IDLE;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end

            ST_IDLE: begin
                if (fire) begin
                    n_ok    = 1'b0;
                    n_cc    = '0;
                    n_ca    = '0;
                    n_state = ST_DONE;
                    case (t_func'(i_req.func))
                        FN_PRINT: begin
                            n_ok = 1'b1;
                            if (i_req.character != NEWLINE_CODE) begin
                                o_we    = 1'b1;
                                o_waddr = r_cur_addr;
                                o_wdata = {i_req.attr, i_req.character};
                            end
                            if (p_scroll) begin
                                n_row      = ROW_W'(ROWS - 1);
                                n_col      = '0;
                                n_cur_addr = AW'(NCELLS - COLUMNS);
                                n_cnt      = '0;
                                n_state    = ST_SCROLL;
                            end else begin
                                n_row      = p_row[ROW_W-1:0];
                                n_col      = p_colf[COL_W-1:0];
                                n_cur_addr = i_au_addr;
                                o_raddr    = i_au_addr;
                                n_state    = ST_PLACE;
                            end
                        end
                        FN_PUT: begin
                            if (i_au_in_bounds) begin
                                n_ok    = 1'b1;
                                o_we    = 1'b1;
                                o_waddr = i_au_addr;
                                o_wdata = {i_req.attr, i_req.character};
                            end
                        end
                        FN_PLACE: begin
                            if (i_au_in_bounds) begin
                                n_ok       = 1'b1;
                                n_row      = i_req.row;
                                n_col      = i_req.col;
                                n_cur_addr = i_au_addr;
                                o_raddr    = i_au_addr;
                                n_state    = ST_PLACE;
                            end
                        end
                        FN_CLR_KEEP: begin
                            n_ok    = 1'b1;
                            n_mark  = 1'b1;
                            n_cnt   = '0;
                            n_state = ST_CLEAR;
                        end
                        FN_CLR_HOME: begin
                            n_ok       = 1'b1;
                            n_mark     = 1'b1;
                            n_cnt      = '0;
                            n_row      = '0;
                            n_col      = '0;
                            n_cur_addr = '0;
                            n_state    = ST_CLEAR;
                        end
                        FN_READ: begin
                            if (i_au_in_bounds) begin
                                n_ok    = 1'b1;
                                o_raddr = i_au_addr;
                                n_state = ST_READ;
                            end
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                end
            end

            ST_PLACE: begin
                // keep the character, replace the attribute
                o_we    = 1'b1;
                o_waddr = r_cur_addr;
                o_wdata = {i_cursor_attr, i_rdata[CHAR_W-1:0]};
                n_state = ST_DONE;
            end

            ST_SCROLL: begin
                // read runs one row ahead of the write, write lands in the cycle after its read
                if (r_cnt < MOVE_CNT) begin
                    o_raddr = AW'(r_cnt + ROW_STEP);
                end
                if (r_cnt != '0) begin
                    o_we    = 1'b1;
                    o_waddr = w_idx[AW-1:0];
                    if (w_idx < MOVE_CNT) begin
                        o_wdata = i_rdata;
                    end else if (w_idx == MOVE_CNT) begin
                        o_wdata = cursor_cell;
                    end
                end
                if (r_cnt == END_IDX) begin
                    n_cnt   = '0;
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end

            ST_READ: begin
                n_cc    = i_rdata[CHAR_W-1:0];
                n_ca    = i_rdata[CELL_W-1:CHAR_W];
                n_state = ST_DONE;
            end

            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_row      <= '0;
            r_col      <= '0;
            r_cur_addr <= '0;
            r_cnt      <= '0;
            r_mark     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_row      <= n_row;
            r_col      <= n_col;
            r_cur_addr <= n_cur_addr;
            r_cnt      <= n_cnt;
            r_mark     <= n_mark;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok <= n_ok;
        r_cc <= n_cc;
        r_ca <= n_ca;
    end

    assign o_res_valid      = (r_state == ST_DONE);
    assign o_res.ok         = r_ok;
    assign o_res.cursor_row = r_row;
    assign o_res.cursor_col = r_col;
    assign o_res.cell_char  = r_cc;
    assign o_res.cell_attr  = r_ca;

endmodule

// ===== rtl/text_console_writer_unit.sv =====
// Text console writer top level: sequencer, address unit, cell memory, response register.
//
// Usage:
//   i_req carries one console command per request (print, put cell, place cursor,
//   clear keeping cursor, clear homing cursor, read cell). o_rsp returns one
//   response per request: ok flag, cursor after the command, and the cell read.
//   The APB port holds cursor_attr at address 0; write it only while idle.
// Steps (N = ROWS*COLUMNS cells, one memory write port and one read port):
//   put cell, read miss, bad position : idle, then response
//   print, place cursor, read cell    : idle, place or read step, then response
//   print that scrolls                : idle, N-cell scroll sweep (one cell moved per cycle), response
//   clear                             : idle, N-cell clear sweep (one cell cleared per cycle), response
//   The response is held in the output register before it appears on o_rsp.
// Reset: the sequencer sweeps the cell memory to zero, one cell per cycle;
//   i_req.ready stays low until the sweep is over.
// Stall: a finished response waits in the output register; the next request
//   is taken and worked on meanwhile, and its result waits for the register.
module text_console_writer_unit #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    tcw_req_if.sink                          i_req,
    tcw_rsp_if.source                        o_rsp,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tcw_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [tcw_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import tcw_pkg::*;

    localparam int NCELLS = ROWS * COLUMNS;
    localparam int AW     = $clog2(NCELLS);

    logic [ATTR_W-1:0] cursor_attr;
    logic [ROW_W-1:0]  au_row;
    logic [COL_W-1:0]  au_col;
    logic [AW-1:0]     au_addr;
    logic              au_in_bounds;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [CELL_W-1:0] wdata;
    logic [AW-1:0]     raddr;
    logic [CELL_W-1:0] rdata;
    logic              res_valid;
    logic              res_ready;
    t_result           res;

    logic              r_out_valid;
    t_result           r_out;

    tcw_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_prdata      (prdata),
        .o_pready      (pready),
        .o_cursor_attr (cursor_attr)
    );

    tcw_addr_unit #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS),
        .AW      (AW)
    ) u_addr (
        .i_row       (au_row),
        .i_col       (au_col),
        .o_addr      (au_addr),
        .o_in_bounds (au_in_bounds)
    );

    tcw_cell_ram #(
        .DEPTH (NCELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    tcw_ctrl #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS),
        .AW      (AW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (i_req),
        .i_cursor_attr  (cursor_attr),
        .o_au_row       (au_row),
        .o_au_col       (au_col),
        .i_au_addr      (au_addr),
        .i_au_in_bounds (au_in_bounds),
        .o_we           (we),
        .o_waddr        (waddr),
        .o_wdata        (wdata),
        .o_raddr        (raddr),
        .i_rdata        (rdata),
        .o_res_valid    (res_valid),
        .o_res          (res),
        .i_res_ready    (res_ready)
    );

    // output register decouples the receiver from the sequencer
    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.ok         = r_out.ok;
    assign o_rsp.cursor_row = r_out.cursor_row;
    assign o_rsp.cursor_col = r_out.cursor_col;
    assign o_rsp.cell_char  = r_out.cell_char;
    assign o_rsp.cell_attr  = r_out.cell_attr;

endmodule
